// ===== sv/nrpn_gain_matrix_writer_top_defines.svh =====
// assertion macros used by the checker file
`ifndef NRPN_GAIN_MATRIX_WRITER_TOP_DEFINES_SVH
`define NRPN_GAIN_MATRIX_WRITER_TOP_DEFINES_SVH

// same-cycle implication
`define NGMW_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NGMW_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ngmw_pkg.sv =====
// shared constants and types of the nrpn gain matrix writer
package ngmw_pkg;

  localparam int CHANNELS      = 16;
  localparam int CHN_W         = 4;
  localparam int VAL_W         = 7;
  localparam int NUM_W         = 14;
  localparam int CNT_W         = 5;
  localparam int LIM_W         = 8;   // holds port limits up to 128
  localparam int IDX_W         = 4;
  localparam int GAIN_W        = 13;
  localparam int DIFF_W        = 15;
  localparam int COEF_W        = 9;
  localparam int PROD_W        = DIFF_W + COEF_W;
  localparam int GAIN_SHIFT    = 9;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_PORTS_DEF = 16;

  localparam logic [3:0]        STATUS_CC    = 4'hB;
  localparam logic [VAL_W-1:0]  CTR_NRPN_LSB = 7'h62;
  localparam logic [VAL_W-1:0]  CTR_NRPN_MSB = 7'h63;
  localparam logic [VAL_W-1:0]  CTR_DATA_LSB = 7'h26;
  localparam logic [VAL_W-1:0]  CTR_DATA_MSB = 7'h06;
  localparam logic [NUM_W-1:0]  DATA_CENTER  = 14'h1fff;
  localparam logic signed [COEF_W-1:0] GAIN_COEF  = 9'sd225;
  localparam logic [GAIN_SHIFT-1:0]    ROUND_BIAS = 9'h1ff;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINKS   = 1'd1;
  localparam logic [CNT_W-1:0]     CNT_RESET   = 5'd1;

  typedef struct packed {
    logic [NUM_W-1:0] param;
    logic [NUM_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] snk;
    logic [NUM_W-1:0] data;
  } gain_req_t;

endpackage

// ===== sv/ngmw_if.sv =====
// handshake channels of the nrpn gain matrix writer
interface ngmw_midi_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_byte;
  logic [6:0] controller_number;
  logic [6:0] controller_value;
  modport source(output valid, status_byte, controller_number, controller_value,
                 input ready);
  modport sink(input valid, status_byte, controller_number, controller_value,
               output ready);
endinterface

interface ngmw_gain_if;
  logic               valid;
  logic               ready;
  logic [3:0]         source_index;
  logic [3:0]         sink_index;
  logic signed [12:0] gain_millibel;
  modport source(output valid, source_index, sink_index, gain_millibel,
                 input ready);
  modport sink(input valid, source_index, sink_index, gain_millibel,
               output ready);
endinterface

interface ngmw_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/ngmw_state.sv =====
// per-channel nrpn state memory with read-modify-write stage
module ngmw_state import ngmw_pkg::*; #(
  parameter int MAX_PORTS = MAX_PORTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       status_byte,
  input  logic [VAL_W-1:0] controller_number,
  input  logic [VAL_W-1:0] controller_value,
  input  logic [CNT_W-1:0] sources_in_use,
  input  logic [CNT_W-1:0] sinks_in_use,
  output logic             req_valid,
  input  logic             req_ready,
  output gain_req_t        req
);

  entry_t               mem [CHANNELS];
  logic [CHANNELS-1:0]  vld;

  logic                 s1_valid;
  logic                 s1_cc;
  logic [CHN_W-1:0]     s1_chn;
  logic [VAL_W-1:0]     s1_ctr;
  logic [VAL_W-1:0]     s1_val;
  entry_t               rd_q;
  logic                 rd_ok;
  logic                 fwd;
  entry_t               fwd_entry;

  entry_t               cur;
  entry_t               entry_next;
  logic                 is_write;
  logic                 is_data;
  logic                 emit;
  logic                 s1_fire;
  logic                 accept;
  logic [LIM_W-1:0]     src_lim;
  logic [LIM_W-1:0]     snk_lim;
  logic [VAL_W-1:0]     hi;
  logic [VAL_W-1:0]     lo;

  // entry written by the previous item wins over the stale memory read
  assign cur = fwd ? fwd_entry : (rd_ok ? rd_q : '0);

  always_comb begin
    entry_next = cur;
    is_write   = 1'b0;
    is_data    = 1'b0;
    unique case (s1_ctr)
      CTR_NRPN_LSB: begin
        entry_next.param[VAL_W-1:0] = s1_val;
        is_write = 1'b1;
      end
      CTR_NRPN_MSB: begin
        entry_next.param[NUM_W-1:VAL_W] = s1_val;
        is_write = 1'b1;
      end
      CTR_DATA_LSB: begin
        entry_next.data[VAL_W-1:0] = s1_val;
        is_write = 1'b1;
        is_data  = 1'b1;
      end
      CTR_DATA_MSB: begin
        entry_next.data[NUM_W-1:VAL_W] = s1_val;
        is_write = 1'b1;
        is_data  = 1'b1;
      end
      default: begin
      end
    endcase
    is_write = is_write && s1_cc;
    is_data  = is_data && s1_cc;
  end

  assign hi = entry_next.param[NUM_W-1:VAL_W];
  assign lo = entry_next.param[VAL_W-1:0];

  // counts above the port limit saturate
  assign src_lim = (LIM_W'(sources_in_use) > LIM_W'(MAX_PORTS)) ?
                   LIM_W'(MAX_PORTS) : LIM_W'(sources_in_use);
  assign snk_lim = (LIM_W'(sinks_in_use) > LIM_W'(MAX_PORTS)) ?
                   LIM_W'(MAX_PORTS) : LIM_W'(sinks_in_use);

  assign emit = is_data && (LIM_W'(hi) < src_lim) && (LIM_W'(lo) < snk_lim);

  assign req_valid = s1_valid && emit;
  assign req.src   = hi[IDX_W-1:0];
  assign req.snk   = lo[IDX_W-1:0];
  assign req.data  = entry_next.data;

  assign s1_fire  = s1_valid && (!emit || req_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      vld      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire && is_write) begin
        vld[s1_chn] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && is_write) begin
      mem[s1_chn] <= entry_next;
    end
    if (accept) begin
      rd_q      <= mem[status_byte[CHN_W-1:0]];
      rd_ok     <= vld[status_byte[CHN_W-1:0]];
      fwd       <= s1_fire && is_write && (s1_chn == status_byte[CHN_W-1:0]);
      fwd_entry <= entry_next;
      s1_cc     <= (status_byte[7:4] == STATUS_CC);
      s1_chn    <= status_byte[CHN_W-1:0];
      s1_ctr    <= controller_number;
      s1_val    <= controller_value;
    end
  end

endmodule

// ===== sv/ngmw_gain.sv =====
// gain scaling pipeline and result register
module ngmw_gain import ngmw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  gain_req_t                req,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [IDX_W-1:0]         source_index,
  output logic [IDX_W-1:0]         sink_index,
  output logic signed [GAIN_W-1:0] gain_millibel
);

  logic                      a_valid;
  gain_req_t                 a_req;
  logic                      b_valid;
  logic [IDX_W-1:0]          b_src;
  logic [IDX_W-1:0]          b_snk;
  logic signed [PROD_W-1:0]  b_prod;

  logic                      a_ready;
  logic                      b_ready;
  logic                      o_ready;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-1:0]  shifted;

  assign o_ready   = !out_valid || out_ready;
  assign b_ready   = !b_valid || o_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_ready = a_ready;

  assign diff = $signed({1'b0, a_req.data}) - $signed({1'b0, DATA_CENTER});
  assign prod = PROD_W'(diff) * PROD_W'(GAIN_COEF);

  // truncate toward zero: bias negative products before the shift
  assign biased  = b_prod + (b_prod[PROD_W-1] ? $signed(PROD_W'(ROUND_BIAS)) : '0);
  assign shifted = biased >>> GAIN_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= req_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (o_ready) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && req_valid) begin
      a_req <= req;
    end
    if (b_ready && a_valid) begin
      b_src  <= a_req.src;
      b_snk  <= a_req.snk;
      b_prod <= prod;
    end
    if (o_ready && b_valid) begin
      source_index  <= b_src;
      sink_index    <= b_snk;
      gain_millibel <= shifted[GAIN_W-1:0];
    end
  end

endmodule

// ===== sv/nrpn_gain_matrix_writer_top.sv =====
// top level of the nrpn gain matrix writer
//
// midi channel: one three-byte midi message per item; only control changes
//   are acted on, other items are taken and dropped
// gain channel: one matrix gain write per item (source, sink, millibels)
// cfg channel: writes sources_in_use (index 0) and sinks_in_use (index 1);
//   always ready, meant to be written while the block is idle
// path: a midi item passes the state read stage, the request register,
//   the multiply stage and the output register in turn
// throughput: one item per cycle when not stalled; the per-channel state
//   memory has one read and one write port, and a write to the channel
//   being read in the same cycle is forwarded into the next item
// reset: counts go to one, every channel's nrpn number and data read as
//   zero (valid bits cleared at once), all pipeline stages empty
// stall: a held result keeps its value; the stages behind it keep taking
//   items until each is full, then midi ready drops
module nrpn_gain_matrix_writer_top import ngmw_pkg::*; #(
  parameter int MAX_PORTS = MAX_PORTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ngmw_midi_if.sink    midi,
  ngmw_gain_if.source  gain,
  ngmw_cfg_if.sink     cfg
);

  // count registers
  logic [CNT_W-1:0] sources_in_use;
  logic [CNT_W-1:0] sinks_in_use;

  // state stage to gain stage
  logic      req_valid;
  logic      req_ready;
  gain_req_t req;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sources_in_use <= CNT_RESET;
      sinks_in_use   <= CNT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SOURCES: sources_in_use <= cfg.data;
        CFG_SINKS:   sinks_in_use   <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // per-channel nrpn/data memory and cell check
  ngmw_state #(
    .MAX_PORTS (MAX_PORTS)
  ) u_state (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (midi.valid),
    .in_ready          (midi.ready),
    .status_byte       (midi.status_byte),
    .controller_number (midi.controller_number),
    .controller_value  (midi.controller_value),
    .sources_in_use    (sources_in_use),
    .sinks_in_use      (sinks_in_use),
    .req_valid         (req_valid),
    .req_ready         (req_ready),
    .req               (req)
  );

  // data to millibel scaling and result register
  ngmw_gain u_gain (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .out_valid     (gain.valid),
    .out_ready     (gain.ready),
    .source_index  (gain.source_index),
    .sink_index    (gain.sink_index),
    .gain_millibel (gain.gain_millibel)
  );

endmodule

// ===== sv/ngmw_checker.sv =====
// port-level checks of the nrpn gain matrix writer and their binding
`include "nrpn_gain_matrix_writer_top_defines.svh"

module ngmw_checker import ngmw_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [IDX_W-1:0]         source_index,
  input logic [IDX_W-1:0]         sink_index,
  input logic signed [GAIN_W-1:0] gain_millibel
);

  localparam logic signed [GAIN_W-1:0] GAIN_MIN = -13'sd3599;
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = 13'sd3600;

  // a held result keeps its payload
  `NGMW_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(source_index) && $stable(sink_index) && $stable(gain_millibel), "result changed while stalled")

  // scaled gain stays within the full-scale range
  `NGMW_ASSERT_IMP(a_gain_range, clk, rst, out_valid, (gain_millibel >= GAIN_MIN) && (gain_millibel <= GAIN_MAX), "gain out of range")

  // reset empties the pipeline
  `NGMW_ASSERT_NXT(a_rst_empty, clk, 1'b0, rst, !out_valid, "result shown after reset")

  // with no result pending every stage can move, so input is taken
  `NGMW_ASSERT_IMP(a_ready_idle, clk, rst, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind nrpn_gain_matrix_writer_top ngmw_checker u_ngmw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (midi.ready),
  .out_valid     (gain.valid),
  .out_ready     (gain.ready),
  .source_index  (gain.source_index),
  .sink_index    (gain.sink_index),
  .gain_millibel (gain.gain_millibel)
);

// ===== dv/tb.sv =====
// self-checking testbench for the nrpn gain matrix writer
`timescale 1ns / 100ps

module tb;
  import ngmw_pkg::*;

  // sender/receiver idle chance in percent, drain wait and run limit
  localparam int IDLE_PCT     = 28;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 172;
  localparam int NUM_PHASES   = 9;

  // status bytes and controllers used as noise in the directed rows
  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] PROG_CHANGE = 8'hc0;
  localparam logic [7:0] POLY_PRESS  = 8'haf;
  localparam logic [6:0] CTR_VOLUME  = 7'h07;

  typedef enum logic [1:0] {ROW_MSG, ROW_CFG} row_kind_t;
  // how a directed row is checked: by the predictor, no write, or a typed write
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_WRITE} row_chk_t;

  typedef struct packed {
    logic [3:0]         src;
    logic [3:0]         snk;
    logic signed [12:0] gain;
  } gain_write_t;

  typedef struct packed {
    row_kind_t          kind;
    row_chk_t           chk;
    logic [7:0]         status;
    logic [6:0]         ctr;
    logic [6:0]         val;
    logic [0:0]         cfg_idx;
    logic [4:0]         cfg_data;
    gain_write_t        typed;
  } stim_row_t;

  logic clk;
  logic rst;
  bit   no_idle;
  int   mismatch_count;
  int   cycle_count;

  ngmw_midi_if midi();
  ngmw_gain_if gain();
  ngmw_cfg_if  cfg();

  nrpn_gain_matrix_writer_top dut (
    .clk  (clk),
    .rst  (rst),
    .midi (midi),
    .gain (gain),
    .cfg  (cfg)
  );

  // ---------------------------------------------------------------------
  // predictor state: per-channel nrpn number and data entry, plus counts
  // ---------------------------------------------------------------------
  logic [13:0]  nrpn_num  [16];
  logic [13:0]  data_word [16];
  logic [4:0]   src_count;
  logic [4:0]   snk_count;
  gain_write_t  pending_gain_writes[$];
  stim_row_t    stim_rows[$];

  // counts above the port limit act as the limit
  function automatic int port_limit(input logic [4:0] c);
    return (c > MAX_PORTS_DEF) ? MAX_PORTS_DEF : int'(c);
  endfunction

  // apply one midi message to the predictor state; returns 1 when a gain
  // write results, with the write in w
  function automatic bit predict_gain_write(input logic [7:0] st, input logic [6:0] ctr,
                                            input logic [6:0] val, output gain_write_t w);
    logic [3:0] chn;
    logic [6:0] hi;
    logic [6:0] lo;
    int         diff;
    int         prod;
    int         mb;
    w = '0;
    if (st[7:4] != STATUS_CC) return 1'b0;
    chn = st[3:0];
    case (ctr)
      CTR_NRPN_LSB: begin
        nrpn_num[chn][6:0] = val;
        return 1'b0;
      end
      CTR_NRPN_MSB: begin
        nrpn_num[chn][13:7] = val;
        return 1'b0;
      end
      CTR_DATA_LSB: data_word[chn][6:0] = val;
      CTR_DATA_MSB: data_word[chn][13:7] = val;
      default: return 1'b0;
    endcase
    hi = nrpn_num[chn][13:7];
    lo = nrpn_num[chn][6:0];
    // data entry is still taken when the cell lies outside the matrix
    if (int'(hi) >= port_limit(src_count) || int'(lo) >= port_limit(snk_count))
      return 1'b0;
    // (data - center) * 3600 / 8192 == * 225 / 512; sv division truncates toward zero
    diff = int'(data_word[chn]) - int'(DATA_CENTER);
    prod = diff * 225;
    mb   = prod / 512;
    w.src  = hi[3:0];
    w.snk  = lo[3:0];
    w.gain = mb[12:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // clock, timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("%0t: run limit reached, %0d gain writes still due", $time,
                 pending_gain_writes.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // gain channel: random backpressure, changed on the falling edge
  // ---------------------------------------------------------------------
  initial begin
    gain.ready = 1'b0;
    forever begin
      @(negedge clk);
      gain.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // each accepted gain write is matched against the oldest one due
  always @(posedge clk) begin
    gain_write_t want;
    if (!rst && gain.valid && gain.ready) begin
      if (pending_gain_writes.size() == 0) begin
        $display("%0t: unexpected gain write src %0d snk %0d gain %0d", $time,
                 gain.source_index, gain.sink_index, $signed(gain.gain_millibel));
        mismatch_count++;
      end else begin
        want = pending_gain_writes.pop_front();
        if (gain.source_index !== want.src) begin
          $display("%0t: source_index expected %0d actual %0d", $time,
                   want.src, gain.source_index);
          mismatch_count++;
        end
        if (gain.sink_index !== want.snk) begin
          $display("%0t: sink_index expected %0d actual %0d", $time,
                   want.snk, gain.sink_index);
          mismatch_count++;
        end
        if (gain.gain_millibel !== want.gain) begin
          $display("%0t: gain_millibel expected %0d actual %0d", $time,
                   $signed(want.gain), $signed(gain.gain_millibel));
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // midi and config drivers; both are entered just after a falling edge
  // ---------------------------------------------------------------------

  // send one midi item, random gaps first; valid stays high for a
  // following item unless the next call idles
  task automatic send_midi(input logic [7:0] st, input logic [6:0] ctr,
                           input logic [6:0] val, input row_chk_t chk,
                           input gain_write_t typed);
    gain_write_t w;
    bit          hit;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      midi.valid <= 1'b0;
      @(negedge clk);
    end
    midi.valid             <= 1'b1;
    midi.status_byte       <= st;
    midi.controller_number <= ctr;
    midi.controller_value  <= val;
    do @(posedge clk); while (!midi.ready);
    // predictor always runs so the state tracks typed rows too
    hit = predict_gain_write(st, ctr, val, w);
    if (chk == CHK_PREDICT && hit) pending_gain_writes.push_back(w);
    if (chk == CHK_WRITE) pending_gain_writes.push_back(typed);
    @(negedge clk);
  endtask

  // let the pipeline run dry, also past items that give no write
  task automatic drain;
    midi.valid <= 1'b0;
    while (pending_gain_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write a count register while the block is idle
  task automatic write_count(input logic [0:0] idx, input logic [4:0] data);
    drain();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == CFG_SOURCES) src_count = data;
    else snk_count = data;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // directed table helpers
  // ---------------------------------------------------------------------
  function automatic void add_msg(input row_chk_t chk, input logic [7:0] st,
                                  input logic [6:0] ctr, input logic [6:0] val,
                                  input logic [3:0] src = '0, input logic [3:0] snk = '0,
                                  input int mb = 0);
    stim_row_t r;
    r        = '0;
    r.kind   = ROW_MSG;
    r.chk    = chk;
    r.status = st;
    r.ctr    = ctr;
    r.val    = val;
    r.typed.src  = src;
    r.typed.snk  = snk;
    r.typed.gain = mb[12:0];
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [0:0] idx, input logic [4:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.cfg_idx  = idx;
    r.cfg_data = data;
    stim_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // random traffic: mostly nrpn/data sequences aimed at the live matrix,
  // some noise; every item sent is counted
  // ---------------------------------------------------------------------
  task automatic run_random_phase(input int target);
    int          sent;
    int          r;
    int          lim;
    logic [7:0]  st;
    logic [6:0]  ctr;
    logic [6:0]  val;
    sent = 0;
    while (sent < target) begin
      r   = $urandom_range(0, 99);
      val = 7'($urandom_range(0, 127));
      if (r < 8) begin
        // anything but a control change
        st  = 8'($urandom_range(0, 255));
        if (st[7:4] == STATUS_CC) st[4] = 1'b0;
        ctr = 7'($urandom_range(0, 127));
      end else if (r < 14) begin
        // control change to any controller
        st  = {STATUS_CC, 4'($urandom_range(0, 15))};
        ctr = 7'($urandom_range(0, 127));
      end else begin
        st = {STATUS_CC, 4'($urandom_range(0, 15))};
        case ($urandom_range(0, 9))
          0, 1: begin
            ctr = CTR_NRPN_MSB;
            lim = port_limit(src_count);
            if ($urandom_range(0, 9) < 6) val = 7'($urandom_range(0, lim));
          end
          2, 3: begin
            ctr = CTR_NRPN_LSB;
            lim = port_limit(snk_count);
            if ($urandom_range(0, 9) < 6) val = 7'($urandom_range(0, lim));
          end
          4, 5, 6: ctr = CTR_DATA_LSB;
          default: ctr = CTR_DATA_MSB;
        endcase
      end
      sent++;
      send_midi(st, ctr, val, CHK_PREDICT, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    int phase_src [NUM_PHASES];
    int phase_snk [NUM_PHASES];
    int s;
    int k;

    // every input known from time zero
    rst                    = 1'b1;
    no_idle                = 1'b0;
    mismatch_count         = 0;
    midi.valid             = 1'b0;
    midi.status_byte       = '0;
    midi.controller_number = '0;
    midi.controller_value  = '0;
    cfg.valid              = 1'b0;
    cfg.index              = CFG_SOURCES;
    cfg.data               = '0;

    // predictor reset state
    for (k = 0; k < 16; k++) begin
      nrpn_num[k]  = '0;
      data_word[k] = '0;
    end
    src_count = CNT_RESET;
    snk_count = CNT_RESET;

    // directed table; counts are one by one after reset, cell 0/0 is live
    // data at zero gives the bottom of the range
    add_msg(CHK_WRITE,   {STATUS_CC, 4'd0}, CTR_DATA_MSB, 7'h00, 4'd0, 4'd0, -3599);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h7f);
    // all ones is the top of the range
    add_msg(CHK_WRITE,   {STATUS_CC, 4'd0}, CTR_DATA_MSB, 7'h7f, 4'd0, 4'd0, 3600);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h7e);
    // one below center rounds toward zero
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd0}, CTR_DATA_MSB, 7'h3f);
    // center is unity gain
    add_msg(CHK_WRITE,   {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h7f, 4'd0, 4'd0, 0);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h00);
    // messages that are not control changes
    add_msg(CHK_NONE, NOTE_ON,     CTR_DATA_MSB, 7'h7f);
    add_msg(CHK_NONE, 8'hff,       7'h7f,        7'h7f);
    add_msg(CHK_NONE, 8'h00,       7'h00,        7'h00);
    add_msg(CHK_NONE, POLY_PRESS,  CTR_DATA_LSB, 7'h7f);
    add_msg(CHK_NONE, PROG_CHANGE, CTR_DATA_MSB, 7'h7f);
    // other controllers
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_VOLUME, 7'h40);
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, 7'h7f,      7'h7f);
    // source outside the matrix: data is stored, no write
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_NRPN_MSB, 7'h01);
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_DATA_MSB, 7'h40);
    // sink outside the matrix
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_NRPN_MSB, 7'h00);
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_NRPN_LSB, 7'h01);
    add_msg(CHK_NONE, {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h55);
    // counts above the port limit saturate
    add_cfg(CFG_SOURCES, 5'd31);
    add_cfg(CFG_SINKS,   5'd31);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd0}, CTR_DATA_LSB, 7'h00);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd15}, CTR_NRPN_MSB, 7'h0f);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd15}, CTR_NRPN_LSB, 7'h0f);
    add_msg(CHK_PREDICT, {STATUS_CC, 4'd15}, CTR_DATA_MSB, 7'h40);
    add_msg(CHK_NONE,    {STATUS_CC, 4'd15}, CTR_NRPN_MSB, 7'h10);
    add_msg(CHK_NONE,    {STATUS_CC, 4'd15}, CTR_DATA_LSB, 7'h7f);
    // a zero count closes the matrix
    add_cfg(CFG_SOURCES, 5'd16);
    add_cfg(CFG_SINKS,   5'd0);
    add_msg(CHK_NONE,    {STATUS_CC, 4'd0}, CTR_DATA_MSB, 7'h00);
    add_cfg(CFG_SOURCES, 5'd0);
    add_cfg(CFG_SINKS,   5'd16);
    add_msg(CHK_NONE,    {STATUS_CC, 4'd15}, CTR_NRPN_MSB, 7'h00);
    add_msg(CHK_NONE,    {STATUS_CC, 4'd15}, CTR_DATA_MSB, 7'h7f);

    // count settings for the random phases; negative means random
    phase_src = '{16, 16, 1, 31, 0, 16, 4, -1, -1};
    phase_snk = '{16, 16, 1, 31, 16, 0, 9, -1, -1};

    // synchronous reset, released on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG)
        write_count(stim_rows[i].cfg_idx, stim_rows[i].cfg_data);
      else
        send_midi(stim_rows[i].status, stim_rows[i].ctr, stim_rows[i].val,
                  stim_rows[i].chk, stim_rows[i].typed);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      s = (phase_src[p] < 0) ? $urandom_range(0, 31) : phase_src[p];
      k = (phase_snk[p] < 0) ? $urandom_range(0, 31) : phase_snk[p];
      write_count(CFG_SOURCES, s[4:0]);
      write_count(CFG_SINKS,   k[4:0]);
      // the first phase runs back to back on both sides
      no_idle = (p == 0);
      run_random_phase(PHASE_ITEMS);
    end
    no_idle = 1'b0;

    // wait out everything still due, then the pipeline latency
    drain();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ngmw_pkg.sv
sv/ngmw_if.sv
sv/ngmw_state.sv
sv/ngmw_gain.sv
sv/nrpn_gain_matrix_writer_top.sv
sv/ngmw_checker.sv
dv/tb.sv
